FILE: hdl/sst_pkg.sv
// shared types and codes for the session slot table
`timescale 1ns / 1ps
package sst_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1800;

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EXPIRED   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now_time;
    logic [30:0] session_key;
  } sst_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [30:0] granted_key;
  } sst_out_t;

endpackage

FILE: hdl/session_slot_table_with_timeout.sv
// session slot table with idle timeout, scanned one slot per cycle
// the scan visits one slot per cycle through one shared subtract-and-compare unit, from slot 0
// up to the deciding slot, and a new transaction is not accepted until the result strobe.
// busy is high from accept until the deciding slot; the result strobe lasts one cycle and
// the next transaction may be accepted during it. the receiver cannot stall.
// reset: all slots inactive, idle_timeout back to 1800, no clearing pass needed.
`timescale 1ns / 1ps
module session_slot_table_with_timeout
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sst_in_t  in_data,
  output logic     out_strobe,
  output sst_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  sst_in_t                 req_r, req_nxt;
  logic [31:0]             timeout_r, timeout_nxt;
  logic [SLOT_COUNT-1:0]   active_r, active_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  sst_out_t                out_data_r, out_data_nxt;

  logic [30:0] key_mem  [SLOT_COUNT];
  logic [31:0] time_mem [SLOT_COUNT];

  logic        cur_active;
  logic [30:0] cur_key;
  logic [31:0] cur_time;
  logic [31:0] idle_ticks;
  logic        expired;
  logic        last_slot;
  logic        mem_we;
  logic        key_we;
  logic [31:0] mem_time;
  logic [SLOT_W+3:0] idx_ext;

  assign busy       = (state_r == S_SCAN);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  assign cur_active = active_r[idx_r];
  assign cur_key    = key_mem[idx_r];
  assign cur_time   = time_mem[idx_r];
  assign idle_ticks = req_r.now_time - cur_time;
  assign expired    = (idle_ticks >= timeout_r);
  assign last_slot  = (idx_r == SLOT_W'(SLOT_COUNT - 1));
  assign idx_ext    = {4'd0, idx_r};

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    req_nxt        = req_r;
    timeout_nxt    = timeout_r;
    active_nxt     = active_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    key_we         = 1'b0;
    mem_time       = req_r.now_time;

    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          timeout_nxt = cfg_wdata;
        end
        if (start) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + SLOT_W'(1);
        case (req_r.operation)
          OP_OPEN: begin
            if (!cur_active || expired) begin
              mem_we            = 1'b1;
              key_we            = 1'b1;
              active_nxt[idx_r] = 1'b1;
              out_strobe_nxt    = 1'b1;
              out_data_nxt      = '{ST_OK, idx_ext[3:0], req_r.session_key};
              state_nxt         = S_IDLE;
            end else if (last_slot) begin
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '{ST_FULL, 4'd0, 31'd0};
              state_nxt      = S_IDLE;
            end
          end
          OP_QUERY, OP_CLOSE: begin
            if (cur_active && (cur_key == req_r.session_key)) begin
              out_strobe_nxt = 1'b1;
              state_nxt      = S_IDLE;
              if (expired) begin
                out_data_nxt = '{ST_EXPIRED, 4'd0, 31'd0};
              end else begin
                mem_we       = 1'b1;
                out_data_nxt = '{ST_OK, idx_ext[3:0], cur_key};
                if (req_r.operation == OP_CLOSE) begin
                  active_nxt[idx_r] = 1'b0;
                  mem_time          = 32'd0;
                end
              end
            end else if (last_slot) begin
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '{ST_NOT_FOUND, 4'd0, 31'd0};
              state_nxt      = S_IDLE;
            end
          end
          default: begin
            out_strobe_nxt = 1'b1;
            out_data_nxt   = '{ST_NOT_FOUND, 4'd0, 31'd0};
            state_nxt      = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= TIMEOUT_RESET;
      active_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      timeout_r    <= timeout_nxt;
      active_r     <= active_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  // slot payload store, no reset: inactive slots are never read for a decision
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[idx_r] <= mem_time;
    end
    if (key_we) begin
      key_mem[idx_r] <= req_r.session_key;
    end
  end

endmodule

FILE: test/tb_session_slot_table_with_timeout.sv
// testbench for the session slot table: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tb_session_slot_table_with_timeout;
  import sst_pkg::*;

  localparam int KEY_POOL_SIZE = 24;
  localparam int MAX_GAP       = 30;
  localparam int PHASE_ITEMS   = 210;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       start     = 1'b0;
  sst_in_t    in_data   = '0;
  logic       busy;
  logic       out_strobe;
  sst_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [31:0] cfg_wdata = '0;

  // predictor state
  logic        slot_live  [SLOT_COUNT];
  logic [30:0] slot_owner [SLOT_COUNT];
  logic [31:0] slot_stamp [SLOT_COUNT];
  logic [31:0] idle_limit;

  sst_out_t    expected_q[$];
  sst_out_t    expected_head;
  int          error_count     = 0;
  int          sender_idle_pct = 16;
  logic [31:0] session_clock   = '0;
  logic [30:0] key_pool [KEY_POOL_SIZE];

  session_slot_table_with_timeout uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic sst_out_t predict_session(sst_in_t req);
    sst_out_t    res;
    logic [31:0] idle;
    bit          done;
    res        = '0;
    res.status = ST_NOT_FOUND;
    done       = 1'b0;
    if (req.operation == OP_OPEN) begin
      res.status = ST_FULL;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        idle = req.now_time - slot_stamp[i];
        if (!done && (!slot_live[i] || idle >= idle_limit)) begin
          slot_live[i]    = 1'b1;
          slot_owner[i]   = req.session_key;
          slot_stamp[i]   = req.now_time;
          res.status      = ST_OK;
          res.slot_index  = i[3:0];
          res.granted_key = req.session_key;
          done            = 1'b1;
        end
      end
    end else if (req.operation == OP_QUERY || req.operation == OP_CLOSE) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        idle = req.now_time - slot_stamp[i];
        if (!done && slot_live[i] && slot_owner[i] == req.session_key) begin
          done = 1'b1;
          if (idle >= idle_limit) begin
            res.status = ST_EXPIRED;
          end else begin
            if (req.operation == OP_CLOSE) begin
              slot_live[i]  = 1'b0;
              slot_stamp[i] = '0;
            end else begin
              slot_stamp[i] = req.now_time;
            end
            res.status      = ST_OK;
            res.slot_index  = i[3:0];
            res.granted_key = slot_owner[i];
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        expected_head = expected_q.pop_front();
        if (out_data.status !== expected_head.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data.status, expected_head.status));
        if (out_data.slot_index !== expected_head.slot_index)
          report_mismatch($sformatf("slot_index got %0d want %0d",
                                    out_data.slot_index, expected_head.slot_index));
        if (out_data.granted_key !== expected_head.granted_key)
          report_mismatch($sformatf("granted_key got %h want %h",
                                    out_data.granted_key, expected_head.granted_key));
      end
    end
  end

  // called on a rising edge; returns on the edge that accepted the transaction
  task automatic send_request(input logic [1:0] op, input logic [31:0] now_t,
                              input logic [30:0] key);
    sst_in_t req;
    int      gap;
    req.operation   = op;
    req.now_time    = now_t;
    req.session_key = key;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_session(req));
  endtask

  task automatic wait_table_idle();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SLOT_COUNT + 2) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    wait_table_idle();
    cfg_wdata <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    idle_limit  = value;
  endtask

  function automatic logic [31:0] advance_clock();
    logic [31:0] step;
    int          sel;
    sel = $urandom_range(99);
    if (sel < 70)
      step = $urandom_range(0, idle_limit >> 3);
    else if (sel < 95)
      step = idle_limit + $urandom_range(0, 4) - 32'd2;
    else
      step = $urandom();
    session_clock += step;
    return session_clock;
  endfunction

  task automatic test_undefined_op();
    send_request(2'd3, 32'd0, 31'd0);
  endtask

  task automatic test_fill_and_full();
    for (int i = 0; i < SLOT_COUNT; i++)
      send_request(OP_OPEN, 32'hFFFF_FFF0 + i, (i == 0) ? 31'h7FFF_FFFF : 31'(i));
    // time wraps past zero, every slot still fresh
    send_request(OP_OPEN, 32'd5, 31'd100);
  endtask

  task automatic test_query_close();
    send_request(OP_QUERY, 32'd100, 31'h7FFF_FFFF);
    send_request(OP_QUERY, 32'd2000, 31'd3);
    send_request(OP_CLOSE, 32'd2000, 31'd3);
    send_request(OP_CLOSE, 32'd200, 31'h7FFF_FFFF);
    send_request(OP_QUERY, 32'd210, 31'h7FFF_FFFF);
    send_request(OP_OPEN, 32'd300, 31'd0);
  endtask

  task automatic test_timeout_extremes();
    write_timeout(32'd0);
    send_request(OP_OPEN, 32'd1234, 31'd5);
    send_request(OP_QUERY, 32'd1234, 31'd5);
    send_request(OP_CLOSE, 32'd1234, 31'd5);
    write_timeout(32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'd1234, 31'd5);
    send_request(OP_QUERY, 32'd1233, 31'd5);
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input logic [31:0] timeout_value);
    logic [1:0]  op;
    logic [31:0] now_t;
    logic [30:0] key;
    int          sel;
    write_timeout(timeout_value);
    sender_idle_pct = idle_pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 12) begin
        op    = 2'($urandom_range(3));
        now_t = $urandom();
        key   = 31'($urandom());
      end else begin
        sel = $urandom_range(99);
        op  = (sel < 45) ? OP_OPEN : (sel < 75) ? OP_QUERY : OP_CLOSE;
        now_t = advance_clock();
        key   = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
      end
      send_request(op, now_t, key);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_live[i]  = 1'b0;
      slot_owner[i] = '0;
      slot_stamp[i] = '0;
    end
    idle_limit = TIMEOUT_RESET;
    key_pool[0] = '0;
    key_pool[1] = 31'h7FFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = 31'($urandom());

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_undefined_op();
    test_fill_and_full();
    test_query_close();
    test_timeout_extremes();
    test_random_traffic(PHASE_ITEMS, 16, $urandom_range(50, 5000));
    test_random_traffic(PHASE_ITEMS, 16, 32'd1);
    test_random_traffic(PHASE_ITEMS, 67, 32'hFFFF_FFFF);
    test_random_traffic(PHASE_ITEMS, 67, $urandom_range(50, 5000));
    test_random_traffic(PHASE_ITEMS, 0, $urandom());
    test_random_traffic(PHASE_ITEMS, 0, TIMEOUT_RESET);

    wait_table_idle();
    if (error_count == 0) begin
      $display("tb_session_slot_table_with_timeout passed");
    end else begin
      $display("tb_session_slot_table_with_timeout failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_session_slot_table_with_timeout failed");
    $finish;
  end

endmodule
